>>> src/fkr_pkg.sv
// Shared constants, types and helpers of the keyed-delete linked-list FIFO.
// Depends on nothing; imported by fifo_with_key_search_remove_core.
package fkr_pkg;

  localparam int DEPTH       = 64;
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 16;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int DATA_W      = KEY_BITS + HANDLE_BITS;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam logic [2:0] KIND_PUSH   = 3'd0;
  localparam logic [2:0] KIND_POP    = 3'd1;
  localparam logic [2:0] KIND_FIND   = 3'd2;
  localparam logic [2:0] KIND_REMOVE = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  function automatic slot_t next_slot(input slot_t s);
    if (s == slot_t'(DEPTH - 1)) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

endpackage

>>> src/fifo_with_key_search_remove_core.sv
// Top level of the ordered FIFO with search and keyed removal.
// Holds the entry and link memories and the sequencer; depends on fkr_pkg.
//
// One beat in gives one beat out. From the accept cycle, push passes through S_PUSH_WB, pop
// through S_POP_WB and S_REL, and clear and rejected operations go straight to S_RESP, which
// loads the output register. Find and remove walk the list from the head in S_WALK and read
// one link per cycle from the link memory; a remove that hits then passes through S_REL. The
// next beat is accepted once the result has moved into the output register. Link entries
// that were never written since reset or clear read as the next slot. One valid flop per
// slot tracks this, so neither reset nor clear needs a pass through memory.
module fifo_with_key_search_remove_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      kind,
  input  logic [fkr_pkg::KEY_BITS-1:0]    key,
  input  logic [fkr_pkg::HANDLE_BITS-1:0] handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [fkr_pkg::KEY_BITS-1:0]    found_key,
  output logic [fkr_pkg::HANDLE_BITS-1:0] found_handle,
  output logic                            is_empty,
  output logic [fkr_pkg::CNT_W-1:0]       occupancy
);
  import fkr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_PUSH_WB = 6'b000010,
    S_POP_WB  = 6'b000100,
    S_WALK    = 6'b001000,
    S_REL     = 6'b010000,
    S_RESP    = 6'b100000
  } state_t;

  state_t state;

  logic [DATA_W-1:0] data_mem [DEPTH];
  slot_t             link_mem [DEPTH];
  logic [DEPTH-1:0]  link_valid;

  logic [DATA_W-1:0] data_rdata;
  slot_t             link_rdata;
  logic              link_vld_rd;
  slot_t             rd_addr_q;

  slot_t first_slot;
  slot_t last_slot;
  slot_t free_first;
  cnt_t  count;

  slot_t                  cur;
  slot_t                  prev;
  cnt_t                   step;
  logic [KEY_BITS-1:0]    key_q;
  logic                   op_remove;
  logic [1:0]             res_status;
  logic [KEY_BITS-1:0]    res_key;
  logic [HANDLE_BITS-1:0] res_handle;

  logic                   accept;
  logic                   rd_en;
  slot_t                  rd_addr;
  logic                   lwe;
  slot_t                  lwa;
  slot_t                  lwd;
  logic                   dwe;
  slot_t                  link_rd;
  logic                   hit;
  logic                   last_step;
  logic                   full;
  logic [KEY_BITS-1:0]    rd_key;
  logic [HANDLE_BITS-1:0] rd_handle;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign link_rd   = link_vld_rd ? link_rdata : next_slot(rd_addr_q);
  assign rd_key    = data_rdata[DATA_W-1:HANDLE_BITS];
  assign rd_handle = data_rdata[HANDLE_BITS-1:0];
  assign hit       = (rd_key == key_q);
  assign last_step = ((step + 1'b1) == count);
  assign full      = (count == cnt_t'(DEPTH));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = first_slot;
    lwe     = 1'b0;
    lwa     = prev;
    lwd     = link_rd;
    dwe     = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_PUSH: begin
              if (!full) begin
                rd_en   = 1'b1;
                rd_addr = free_first;
                dwe     = 1'b1;
              end
            end
            KIND_POP, KIND_FIND, KIND_REMOVE: begin
              rd_en = (count != '0);
            end
            default: begin
            end
          endcase
        end
      end
      S_PUSH_WB: begin
        if (count != '0) begin
          lwe = 1'b1;
          lwa = last_slot;
          lwd = cur;
        end
      end
      S_WALK: begin
        if (hit) begin
          lwe = op_remove && (step != '0);
        end else if (!last_step) begin
          rd_en   = 1'b1;
          rd_addr = link_rd;
        end
      end
      S_REL: begin
        lwe = 1'b1;
        lwa = cur;
        lwd = free_first;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dwe) begin
      data_mem[free_first] <= {key, handle};
    end
    if (lwe) begin
      link_mem[lwa] <= lwd;
    end
    if (rd_en) begin
      data_rdata  <= data_mem[rd_addr];
      link_rdata  <= link_mem[rd_addr];
      link_vld_rd <= link_valid[rd_addr];
      rd_addr_q   <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      first_slot <= '0;
      last_slot  <= '0;
      free_first <= '0;
      count      <= '0;
      link_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (lwe) begin
        link_valid[lwa] <= 1'b1;
      end
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            key_q      <= key;
            op_remove  <= (kind == KIND_REMOVE);
            res_status <= STAT_OK;
            res_key    <= '0;
            res_handle <= '0;
            cur        <= first_slot;
            prev       <= first_slot;
            step       <= '0;
            state      <= S_RESP;
            case (kind)
              KIND_PUSH: begin
                if (full) begin
                  res_status <= STAT_FULL;
                end else begin
                  cur   <= free_first;
                  state <= S_PUSH_WB;
                end
              end
              KIND_POP: begin
                if (count == '0) begin
                  res_status <= STAT_EMPTY;
                end else begin
                  state <= S_POP_WB;
                end
              end
              KIND_FIND, KIND_REMOVE: begin
                if (count == '0) begin
                  res_status <= STAT_MISS;
                end else begin
                  state <= S_WALK;
                end
              end
              KIND_CLEAR: begin
                first_slot <= '0;
                last_slot  <= '0;
                free_first <= '0;
                count      <= '0;
                link_valid <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_PUSH_WB: begin
          free_first <= link_rd;
          if (count == '0) begin
            first_slot <= cur;
          end
          last_slot <= cur;
          count     <= count + 1'b1;
          state     <= S_RESP;
        end
        S_POP_WB: begin
          res_key    <= rd_key;
          res_handle <= rd_handle;
          first_slot <= link_rd;
          state      <= S_REL;
        end
        S_WALK: begin
          if (hit) begin
            res_key    <= rd_key;
            res_handle <= rd_handle;
            if (op_remove) begin
              if (step == '0) begin
                first_slot <= link_rd;
              end else if (cur == last_slot) begin
                last_slot <= prev;
              end
              state <= S_REL;
            end else begin
              state <= S_RESP;
            end
          end else if (last_step) begin
            res_status <= STAT_MISS;
            state      <= S_RESP;
          end else begin
            prev <= cur;
            cur  <= link_rd;
            step <= step + 1'b1;
          end
        end
        S_REL: begin
          free_first <= cur;
          count      <= count - 1'b1;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            found_key    <= res_key;
            found_handle <= res_handle;
            is_empty     <= (count == '0);
            occupancy    <= count;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(DEPTH))
    else $error("entry count exceeds depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_CLEAR) |=> (count == '0))
    else $error("clear left entries in the queue");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (step < count))
    else $error("list walk ran past the entry count");

endmodule
